@@ src/round_robin_ready_queue_macros.svh @@
// Assertion macros for the ready queue RTL.
`ifndef ROUND_ROBIN_READY_QUEUE_MACROS_SVH
`define ROUND_ROBIN_READY_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rrq_pkg.sv @@
// Package with the types and constants of the round-robin ready queue.
`timescale 1ns / 1ps

package rrq_pkg;

    localparam int C_DEPTH        = 16;
    localparam int C_HANDLE_WIDTH = 16;
    localparam int C_FIELD_W      = 16;
    localparam int C_OCC_W        = 5;

    typedef enum logic [1:0] {
        KIND_ENQUEUE = 2'd0,
        KIND_DEQUEUE = 2'd1,
        KIND_ADVANCE = 2'd2,
        KIND_REMOVE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_APPLY,
        S_SHIFT,
        S_RD_CUR,
        S_RD_HEAD,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_status              status;
        logic [C_FIELD_W-1:0] item_out;
        logic [C_FIELD_W-1:0] current_item;
        logic [C_FIELD_W-1:0] front_item;
        logic [C_OCC_W-1:0]   occupancy;
        logic                 is_empty;
        logic                 is_full;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_push;

endpackage

@@ src/rrq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module rrq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/rrq_ctrl.sv @@
// Sequencer that applies one queue operation to the entry RAM and index registers.
`timescale 1ns / 1ps

module rrq_ctrl import rrq_pkg::*; #(
    parameter int DEPTH        = C_DEPTH,
    parameter int HANDLE_WIDTH = C_HANDLE_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_kind                    i_kind,
    input  logic [C_FIELD_W-1:0]     i_item_in,
    output t_push                    o_push,
    input  logic                     i_push_ready,
    output logic                     o_ram_wr_en,
    output logic [$clog2(DEPTH)-1:0] o_ram_wr_addr,
    output logic [HANDLE_WIDTH-1:0]  o_ram_wr_data,
    output logic                     o_ram_rd_en,
    output logic [$clog2(DEPTH)-1:0] o_ram_rd_addr,
    input  logic [HANDLE_WIDTH-1:0]  i_ram_rd_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        next_slot = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] idx);
        prev_slot = (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
    endfunction

    function automatic logic [C_FIELD_W-1:0] to_field(input logic [HANDLE_WIDTH-1:0] h);
        logic [31:0] wide;
        wide     = 32'(h);
        to_field = wide[C_FIELD_W-1:0];
    endfunction

    t_state                  r_state, n_state;
    t_kind                   r_kind, n_kind;
    t_status                 r_status, n_status;
    logic [HANDLE_WIDTH-1:0] r_handle, n_handle;
    logic [HANDLE_WIDTH-1:0] r_removed, n_removed;
    logic [HANDLE_WIDTH-1:0] r_cur_item, n_cur_item;
    logic [IDX_W-1:0]        r_head, n_head;
    logic [IDX_W-1:0]        r_tail, n_tail;
    logic [IDX_W-1:0]        r_cur, n_cur;
    logic [IDX_W-1:0]        r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]        r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]        r_count, n_count;

    logic                    w_empty;
    logic                    w_full;
    logic                    w_mid_remove;
    logic [31:0]             w_in_wide;
    logic [31:0]             w_occ_wide;

    assign w_empty      = (r_count == '0);
    assign w_full       = (r_count == CNT_W'(DEPTH));
    assign w_mid_remove = (r_kind == KIND_REMOVE) && !w_empty && (r_head != r_tail)
                          && (r_cur != r_tail) && (r_cur != r_head);
    assign w_in_wide    = 32'(i_item_in);
    assign w_occ_wide   = 32'(r_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_FETCH;
            S_FETCH:   n_state = S_APPLY;
            S_APPLY:   n_state = w_mid_remove ? S_SHIFT : S_RD_CUR;
            S_SHIFT:   if (r_rd_idx == r_tail) n_state = S_RD_CUR;
            S_RD_CUR:  n_state = S_RD_HEAD;
            S_RD_HEAD: n_state = S_FINISH;
            S_FINISH:  if (i_push_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Outputs: handshake and RAM port control.
    always_comb begin
        o_in_ready    = 1'b0;
        o_push.valid  = 1'b0;
        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = r_wr_idx;
        o_ram_wr_data = i_ram_rd_data;
        o_ram_rd_en   = 1'b0;
        o_ram_rd_addr = r_cur;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_FETCH: begin
                o_ram_rd_en   = 1'b1;
                o_ram_rd_addr = (r_kind == KIND_DEQUEUE) ? r_head : r_cur;
            end
            S_APPLY: begin
                if (r_kind == KIND_ENQUEUE && !w_full) begin
                    o_ram_wr_en   = 1'b1;
                    o_ram_wr_addr = w_empty ? '0 : next_slot(r_tail);
                    o_ram_wr_data = r_handle;
                end
                if (w_mid_remove) begin
                    o_ram_rd_en   = 1'b1;
                    o_ram_rd_addr = next_slot(r_cur);
                end
            end
            S_SHIFT: begin
                // Entry at the read index moves down into the write index.
                o_ram_wr_en   = 1'b1;
                o_ram_wr_addr = r_wr_idx;
                o_ram_wr_data = i_ram_rd_data;
                if (r_rd_idx != r_tail) begin
                    o_ram_rd_en   = 1'b1;
                    o_ram_rd_addr = next_slot(r_rd_idx);
                end
            end
            S_RD_CUR: begin
                o_ram_rd_en   = 1'b1;
                o_ram_rd_addr = r_cur;
            end
            S_RD_HEAD: begin
                o_ram_rd_en   = 1'b1;
                o_ram_rd_addr = r_head;
            end
            S_FINISH: begin
                o_push.valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Index and payload updates.
    always_comb begin
        n_kind     = r_kind;
        n_status   = r_status;
        n_handle   = r_handle;
        n_removed  = r_removed;
        n_cur_item = r_cur_item;
        n_head     = r_head;
        n_tail     = r_tail;
        n_cur      = r_cur;
        n_wr_idx   = r_wr_idx;
        n_rd_idx   = r_rd_idx;
        n_count    = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind   = i_kind;
                    n_handle = w_in_wide[HANDLE_WIDTH-1:0];
                end
            end
            S_APPLY: begin
                n_status  = ST_OK;
                n_removed = '0;
                if (r_kind == KIND_ENQUEUE) begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else if (w_empty) begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_cur   = '0;
                        n_count = CNT_W'(1);
                    end else begin
                        n_tail  = next_slot(r_tail);
                        n_count = r_count + 1'b1;
                    end
                end else if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (r_kind == KIND_DEQUEUE) begin
                    if (r_cur == r_head) n_cur = next_slot(r_cur);
                    n_removed = i_ram_rd_data;
                    n_head    = next_slot(r_head);
                    n_count   = r_count - 1'b1;
                end else if (r_kind == KIND_ADVANCE) begin
                    n_cur = (r_cur == r_tail) ? r_head : next_slot(r_cur);
                end else begin
                    n_removed = i_ram_rd_data;
                    if (r_head == r_tail) begin
                        n_count = '0;
                    end else if (r_cur == r_tail) begin
                        n_tail  = prev_slot(r_tail);
                        n_cur   = r_head;
                        n_count = r_count - 1'b1;
                    end else if (r_cur == r_head) begin
                        n_head  = next_slot(r_head);
                        n_cur   = next_slot(r_head);
                        n_count = r_count - 1'b1;
                    end else begin
                        n_wr_idx = r_cur;
                        n_rd_idx = next_slot(r_cur);
                    end
                end
            end
            S_SHIFT: begin
                if (r_rd_idx == r_tail) begin
                    n_tail  = prev_slot(r_tail);
                    n_count = r_count - 1'b1;
                end else begin
                    n_wr_idx = r_rd_idx;
                    n_rd_idx = next_slot(r_rd_idx);
                end
            end
            S_RD_HEAD: begin
                n_cur_item = i_ram_rd_data;
            end
            default: begin
                n_kind = r_kind;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_cur   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cur   <= n_cur;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_status   <= n_status;
        r_handle   <= n_handle;
        r_removed  <= n_removed;
        r_cur_item <= n_cur_item;
        r_wr_idx   <= n_wr_idx;
        r_rd_idx   <= n_rd_idx;
    end

    // In the finishing state the RAM still holds the head entry on its read port.
    assign o_push.result.status       = r_status;
    assign o_push.result.item_out     = to_field(r_removed);
    assign o_push.result.current_item = w_empty ? '0 : to_field(r_cur_item);
    assign o_push.result.front_item   = w_empty ? '0 : to_field(i_ram_rd_data);
    assign o_push.result.occupancy    = w_occ_wide[C_OCC_W-1:0];
    assign o_push.result.is_empty     = w_empty;
    assign o_push.result.is_full      = w_full;

endmodule

@@ src/rrq_out_stage.sv @@
// Output register that holds one result until the downstream side takes it.
`timescale 1ns / 1ps

module rrq_out_stage import rrq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_push_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_push_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid && o_push_ready) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid && o_push_ready) begin
            r_result <= i_push.result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ src/round_robin_ready_queue.sv @@
// Top level of the round-robin ready queue of process handles.
//
//   Channel   Direction  tdata (lowest bit up)                         tuser
//   s_axis    in         item_in[15:0]                                 kind[1:0]
//   m_axis    out        item_out, current_item, front_item,           status[1:0]
//                        occupancy[4:0], is_empty, is_full, pad bit
//
// An operation holds the sequencer through the fetch, apply, read-current, read-head and
// finishing states, plus a shift state for each entry after current when current is removed
// from the middle; the single read port of the entry RAM sets this, since each shifted
// entry and each reported handle takes one read. The next transaction is taken in idle.
// Reset clears the indices and the count; the entry RAM is left as it is and only used
// where an enqueue has written. A result waits in the output register while a new
// transaction is accepted; the sequencer stalls in its finishing state if it is still full.
`timescale 1ns / 1ps

module round_robin_ready_queue import rrq_pkg::*; #(
    parameter int DEPTH        = C_DEPTH,
    parameter int HANDLE_WIDTH = C_HANDLE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // item_in[15:0]
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // item_out, current_item, front_item, occupancy,
                                        // is_empty, is_full, zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

`include "round_robin_ready_queue_macros.svh"

    localparam int IDX_W = $clog2(DEPTH);

    t_push                   w_push;
    logic                    w_push_ready;
    t_result                 w_result;
    logic                    w_ram_wr_en;
    logic [IDX_W-1:0]        w_ram_wr_addr;
    logic [HANDLE_WIDTH-1:0] w_ram_wr_data;
    logic                    w_ram_rd_en;
    logic [IDX_W-1:0]        w_ram_rd_addr;
    logic [HANDLE_WIDTH-1:0] w_ram_rd_data;

    // Entry store: one handle per slot of the ring.
    rrq_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (w_ram_wr_addr),
        .i_wr_data (w_ram_wr_data),
        .i_rd_en   (w_ram_rd_en),
        .i_rd_addr (w_ram_rd_addr),
        .o_rd_data (w_ram_rd_data)
    );

    // Sequencer: reads, modifies and writes back the ring for one operation at a time.
    rrq_ctrl #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_kind        (t_kind'(s_axis_tuser)),
        .i_item_in     (s_axis_tdata),
        .o_push        (w_push),
        .i_push_ready  (w_push_ready),
        .o_ram_wr_en   (w_ram_wr_en),
        .o_ram_wr_addr (w_ram_wr_addr),
        .o_ram_wr_data (w_ram_wr_data),
        .o_ram_rd_en   (w_ram_rd_en),
        .o_ram_rd_addr (w_ram_rd_addr),
        .i_ram_rd_data (w_ram_rd_data)
    );

    // Output register that decouples the result from the next operation.
    rrq_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (w_result)
    );

    // Result fields packed from the lowest bit up, with one zero bit to fill the byte.
    assign m_axis_tdata = {1'b0, w_result.is_full, w_result.is_empty, w_result.occupancy,
                           w_result.front_item, w_result.current_item, w_result.item_out};
    assign m_axis_tuser = w_result.status;

    // The sequencer never takes a transaction while it is presenting a result.
    `RRQ_ASSERT_NOW(a_idle_excl, i_clk, i_rst_n, w_push.valid, !s_axis_tready,
                    "ready while finishing")
    // After a transaction the sequencer is not ready in the next cycle.
    `RRQ_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
                     !s_axis_tready, "ready right after accept")
    // A full status is only reported while the queue is full.
    `RRQ_ASSERT_NOW(a_full_flag, i_clk, i_rst_n,
                    m_axis_tvalid && (w_result.status == ST_FULL), w_result.is_full,
                    "full status without full flag")
    // An empty status is only reported while the queue is empty and nothing is removed.
    `RRQ_ASSERT_NOW(a_empty_flag, i_clk, i_rst_n,
                    m_axis_tvalid && (w_result.status == ST_EMPTY),
                    w_result.is_empty && (w_result.item_out == '0),
                    "empty status with entries")

endmodule
